@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define SDF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("spring damper check failed");

// Concurrent assertion that is also checked across reset.
`define SDF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("spring damper reset check failed");

`endif

@@ design/sdf_pkg.sv @@
// Package with the shared types, constants and helpers of the spring damper follower.
`timescale 1ns / 1ps
package sdf_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned AXES    = 6;
    localparam int unsigned ROOT_W  = 32;
    localparam int unsigned QUO_W   = 48;
    localparam int unsigned DEN_W   = 33;

    localparam logic [1:0] CFG_SPRING_GAIN   = 2'd0;
    localparam logic [1:0] CFG_DAMPING       = 2'd1;
    localparam logic [1:0] CFG_REST_DISTANCE = 2'd2;

    localparam logic [15:0] SPRING_GAIN_RST   = 16'd1638;
    localparam logic [15:0] DAMPING_RST       = 16'd32768;
    localparam logic [31:0] REST_DISTANCE_RST = 32'd655360;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SNAP,
        S_SQ,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DIV_WAIT,
        S_AX_MUL,
        S_AX_ADD,
        S_AX_DAMP,
        S_AX_WB,
        S_DONE
    } sdf_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/sdf_isqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module sdf_isqrt
    import sdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*ROOT_W-1:0]   radicand,
    output logic                  done,
    output logic [ROOT_W-1:0]     root
);

    localparam int unsigned REM_W = ROOT_W + 4;
    localparam int unsigned CNT_W = $clog2(ROOT_W);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                ge;

    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[2*ROOT_W-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[2*ROOT_W-3:0], 2'b00};
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ design/sdf_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sdf_div
    import sdf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [QUO_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUO_W-1:0]  quo
);

    localparam int unsigned REM_W = DEN_W + 1;
    localparam int unsigned CNT_W = $clog2(QUO_W);

    logic [QUO_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg[DEN_W-1:0], num_reg[QUO_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[QUO_W-2:0], 1'b0};
            rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ design/spring_damper_follow_3d.sv @@
// Top level of the spring damper follower for a camera eye point and target point.
//
// The s_ channel takes one request: a raw eye point, a raw target point (signed
// Q16.16) and a snap flag. The m_ channel returns one request per input with the
// smoothed eye and target points. Both channels use valid and ready.
// A request that snaps (first one after reset, or snap set) goes through the
// snap step to the result. A smoothing request goes through the squaring of
// the three eye-to-target offsets, a bit-serial square root, a bit-serial
// divide for the gain and the multiply, add, damp and write-back steps for each
// of six axes. When the two points coincide the divide is skipped. One request
// is in work at a time, and the next one can be accepted in the cycle after the
// result is loaded. Reset restores the default registers and arms the block so
// that the next request snaps. A stalled receiver holds the result in the output
// register; the next request is still accepted and worked on, and its result
// waits until the output register is free. The user writes the registers through
// cfg_wr_en, cfg_index and cfg_wr_data only while idle; the block does not enforce it.
`timescale 1ns / 1ps
module spring_damper_follow_3d
    import sdf_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [COORD_W-1:0]  s_eye_x,
    input  logic signed [COORD_W-1:0]  s_eye_y,
    input  logic signed [COORD_W-1:0]  s_eye_z,
    input  logic signed [COORD_W-1:0]  s_aim_x,
    input  logic signed [COORD_W-1:0]  s_aim_y,
    input  logic signed [COORD_W-1:0]  s_aim_z,
    input  logic                       s_snap,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COORD_W-1:0]  m_smooth_eye_x,
    output logic signed [COORD_W-1:0]  m_smooth_eye_y,
    output logic signed [COORD_W-1:0]  m_smooth_eye_z,
    output logic signed [COORD_W-1:0]  m_smooth_aim_x,
    output logic signed [COORD_W-1:0]  m_smooth_aim_y,
    output logic signed [COORD_W-1:0]  m_smooth_aim_z,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [31:0]                cfg_wr_data
);

    sdf_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] raw_reg [AXES];
    logic signed [COORD_W-1:0] raw_next [AXES];
    logic signed [COORD_W-1:0] pos_reg [AXES];
    logic signed [COORD_W-1:0] pos_next [AXES];
    logic signed [COORD_W-1:0] vel_reg [AXES];
    logic signed [COORD_W-1:0] vel_next [AXES];
    logic signed [COORD_W-1:0] out_reg [AXES];
    logic signed [COORD_W-1:0] out_next [AXES];

    logic        armed_reg, armed_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] spring_gain_reg, spring_gain_next;
    logic [15:0] damping_reg, damping_next;
    logic [31:0] rest_dist_reg, rest_dist_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] sum_reg, sum_next;
    logic        sh_reg, sh_next;
    logic [QUO_W-1:0] gain_reg, gain_next;
    logic        neg_reg, neg_next;
    logic [64:0] ph_reg, ph_next;
    logic [48:0] pl_reg, pl_next;
    logic signed [31:0] v_reg, v_next;
    logic signed [48:0] prod_reg, prod_next;

    logic              s_fire;
    logic              out_load;
    logic [32:0]       mag [3];
    logic              sh_c;
    logic [31:0]       sq_t;
    logic [ROOT_W-1:0] root;
    logic              root_done;
    logic [DEN_W-1:0]  dist_c;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  quo;
    logic [QUO_W-1:0]  num_c;
    logic signed [32:0] diff_c;
    logic [32:0]       m_c;
    logic [64:0]       r_c;
    logic signed [65:0] vsum_c;
    logic [48:0]       pm_c;
    logic [32:0]       dm_c;
    logic signed [33:0] damp_c;
    logic signed [33:0] v2_c;
    logic signed [COORD_W-1:0] vel_new_c;

    assign s_fire   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Axis magnitudes of eye minus target; the shift keeps every square below 2^62.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [32:0] d;
            d = 33'(raw_reg[i]) - 33'(raw_reg[i+3]);
            mag[i] = d[32] ? 33'(-d) : 33'(d);
        end
    end
    assign sh_c = mag[0][32] | mag[0][31] | mag[1][32] | mag[1][31]
                | mag[2][32] | mag[2][31];

    always_comb begin
        logic [32:0] a;
        case (cnt_reg[1:0])
            2'd0:    a = mag[0];
            2'd1:    a = mag[1];
            default: a = mag[2];
        endcase
        sq_t = sh_c ? a[32:1] : a[31:0];
    end

    assign dist_c    = sh_reg ? {root, 1'b0} : {1'b0, root};
    assign num_c     = QUO_W'(spring_gain_reg) * QUO_W'(rest_dist_reg);
    assign div_start = (state_reg == S_ROOT_WAIT) && root_done && (dist_c != '0);

    sdf_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == S_ROOT_GO),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (root)
    );

    sdf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_c),
        .den     (dist_c),
        .done    (div_done),
        .quo     (quo)
    );

    // Per-axis arithmetic on the axis that cnt_reg selects.
    assign diff_c = 33'(raw_reg[cnt_reg]) - 33'(pos_reg[cnt_reg]);
    assign m_c    = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);
    assign r_c    = (ph_reg + 65'(pl_reg >> 16)) >> 16;
    assign vsum_c = 66'(vel_reg[cnt_reg])
                  + (neg_reg ? -$signed({1'b0, r_c}) : $signed({1'b0, r_c}));
    assign pm_c   = prod_reg[48] ? 49'(-prod_reg) : 49'(prod_reg);
    assign dm_c   = pm_c[48:16];
    assign damp_c = prod_reg[48] ? -$signed({1'b0, dm_c}) : $signed({1'b0, dm_c});
    assign v2_c   = 34'(v_reg) - damp_c;
    assign vel_new_c = v2_c[31:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (armed_reg || s_snap) ? S_SNAP : S_SQ;
                end
            end
            S_SNAP:      state_next = S_DONE;
            S_SQ: begin
                if (cnt_reg == 3'd2) begin
                    state_next = S_ROOT_GO;
                end
            end
            S_ROOT_GO:   state_next = S_ROOT_WAIT;
            S_ROOT_WAIT: begin
                if (root_done) begin
                    state_next = (dist_c != '0) ? S_DIV_WAIT : S_AX_MUL;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    state_next = S_AX_MUL;
                end
            end
            S_AX_MUL:    state_next = S_AX_ADD;
            S_AX_ADD:    state_next = S_AX_DAMP;
            S_AX_DAMP:   state_next = S_AX_WB;
            S_AX_WB: begin
                state_next = (cnt_reg == 3'(AXES - 1)) ? S_DONE : S_AX_MUL;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        raw_next         = raw_reg;
        pos_next         = pos_reg;
        vel_next         = vel_reg;
        out_next         = out_reg;
        armed_next       = armed_reg;
        cnt_next         = cnt_reg;
        sum_next         = sum_reg;
        sh_next          = sh_reg;
        gain_next        = gain_reg;
        neg_next         = neg_reg;
        ph_next          = ph_reg;
        pl_next          = pl_reg;
        v_next           = v_reg;
        prod_next        = prod_reg;
        spring_gain_next = spring_gain_reg;
        damping_next     = damping_reg;
        rest_dist_next   = rest_dist_reg;
        m_valid_next     = m_valid_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SPRING_GAIN:   spring_gain_next = cfg_wr_data[15:0];
                CFG_DAMPING:       damping_next     = cfg_wr_data[15:0];
                CFG_REST_DISTANCE: rest_dist_next   = cfg_wr_data;
                default:           ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    raw_next[0] = s_eye_x;
                    raw_next[1] = s_eye_y;
                    raw_next[2] = s_eye_z;
                    raw_next[3] = s_aim_x;
                    raw_next[4] = s_aim_y;
                    raw_next[5] = s_aim_z;
                    cnt_next    = '0;
                    sum_next    = '0;
                end
            end
            S_SNAP: begin
                for (int i = 0; i < AXES; i++) begin
                    pos_next[i] = raw_reg[i];
                    vel_next[i] = '0;
                end
                armed_next = 1'b0;
            end
            S_SQ: begin
                sh_next  = sh_c;
                sum_next = sum_reg + (64'(sq_t) * 64'(sq_t));
                cnt_next = (cnt_reg == 3'd2) ? 3'd0 : cnt_reg + 3'd1;
            end
            S_ROOT_WAIT: begin
                if (root_done && (dist_c == '0)) begin
                    gain_next = '0;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    gain_next = quo;
                end
            end
            S_AX_MUL: begin
                neg_next = diff_c[32];
                ph_next  = 65'(m_c) * 65'(gain_reg[QUO_W-1:16]);
                pl_next  = 49'(m_c) * 49'(gain_reg[15:0]);
            end
            S_AX_ADD: begin
                v_next = sat32(vsum_c);
            end
            S_AX_DAMP: begin
                prod_next = 49'(v_reg) * $signed({33'b0, damping_reg});
            end
            S_AX_WB: begin
                vel_next[cnt_reg] = vel_new_c;
                pos_next[cnt_reg] = sat32(66'(pos_reg[cnt_reg]) + 66'(vel_new_c));
                cnt_next          = cnt_reg + 3'd1;
            end
            default: ;
        endcase

        if (out_load) begin
            out_next     = pos_reg;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            armed_reg       <= 1'b1;
            m_valid_reg     <= 1'b0;
            spring_gain_reg <= SPRING_GAIN_RST;
            damping_reg     <= DAMPING_RST;
            rest_dist_reg   <= REST_DISTANCE_RST;
        end else begin
            state_reg       <= state_next;
            armed_reg       <= armed_next;
            m_valid_reg     <= m_valid_next;
            spring_gain_reg <= spring_gain_next;
            damping_reg     <= damping_next;
            rest_dist_reg   <= rest_dist_next;
        end
        raw_reg  <= raw_next;
        pos_reg  <= pos_next;
        vel_reg  <= vel_next;
        out_reg  <= out_next;
        cnt_reg  <= cnt_next;
        sum_reg  <= sum_next;
        sh_reg   <= sh_next;
        gain_reg <= gain_next;
        neg_reg  <= neg_next;
        ph_reg   <= ph_next;
        pl_reg   <= pl_next;
        v_reg    <= v_next;
        prod_reg <= prod_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_smooth_eye_x = out_reg[0];
    assign m_smooth_eye_y = out_reg[1];
    assign m_smooth_eye_z = out_reg[2];
    assign m_smooth_aim_x = out_reg[3];
    assign m_smooth_aim_y = out_reg[4];
    assign m_smooth_aim_z = out_reg[5];

endmodule

@@ design/sdf_checker.sv @@
// Port-level checker for the spring damper follower and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_smooth_eye_x
);

    `SDF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `SDF_ASSERT(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_smooth_eye_x))
    // One request is in work at a time, so acceptance closes the input side.
    `SDF_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready)
    // A result is loaded only as the block returns to idle.
    `SDF_ASSERT(a_load_to_idle, aclk, aresetn, $rose(m_valid) |-> s_ready)
    `SDF_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind spring_damper_follow_3d sdf_checker u_sdf_checker (.*);

@@ test/sdf_follow_checker.sv @@
// Checker for the spring damper follower: predicts smoothed points and compares results.
`timescale 1ns / 1ps
module sdf_follow_checker
    import sdf_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_eye_x,
    input  logic signed [COORD_W-1:0] s_eye_y,
    input  logic signed [COORD_W-1:0] s_eye_z,
    input  logic signed [COORD_W-1:0] s_aim_x,
    input  logic signed [COORD_W-1:0] s_aim_y,
    input  logic signed [COORD_W-1:0] s_aim_z,
    input  logic                      s_snap,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [COORD_W-1:0] m_smooth_eye_x,
    input  logic signed [COORD_W-1:0] m_smooth_eye_y,
    input  logic signed [COORD_W-1:0] m_smooth_eye_z,
    input  logic signed [COORD_W-1:0] m_smooth_aim_x,
    input  logic signed [COORD_W-1:0] m_smooth_aim_y,
    input  logic signed [COORD_W-1:0] m_smooth_aim_z,
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_wr_data,
    output int                        n_pending,
    output int                        n_errors
);

    // Axes 0..2 are the eye point, 3..5 the target point.
    typedef logic [5:0][31:0] pose_t;

    pose_t         pose_q[$];
    logic [15:0]   k_spring;
    logic [15:0]   k_damp;
    logic [31:0]   k_rest;
    logic [31:0]   cur_pos[6];
    logic [31:0]   cur_vel[6];
    logic          want_snap;

    initial begin
        n_pending = 0;
        n_errors  = 0;
    end

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n   = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Spring pull: offset times the gain (units of 2^-32), truncated toward zero.
    function automatic longint spring_pull(longint d, logic [63:0] g);
        logic [63:0] m;
        logic [63:0] r;
        m = abs64(d);
        r = (m * (g >> 16) + ((m * (g & 64'hFFFF)) >> 16)) >> 16;
        return d < 0 ? -longint'(r) : longint'(r);
    endfunction

    task automatic follow_step(input logic [31:0] raw_pt[6], input logic snap_req);
        longint      raw_s[6];
        logic [63:0] offs[6];
        logic [63:0] sum;
        logic [63:0] span;
        logic [63:0] g;
        longint      v;
        longint      prod;
        logic [63:0] dm;
        int          sh;
        pose_t       exp_pose;
        for (int i = 0; i < 6; i++) raw_s[i] = longint'($signed(raw_pt[i]));
        if (want_snap || snap_req) begin
            for (int i = 0; i < 6; i++) begin
                cur_pos[i] = raw_pt[i];
                cur_vel[i] = 0;
            end
            want_snap = 1'b0;
        end else begin
            sh  = 0;
            sum = 0;
            g   = 0;
            for (int i = 0; i < 3; i++) begin
                offs[i] = abs64(raw_s[i] - raw_s[i + 3]);
                if (offs[i] >= 64'h8000_0000) sh = 1;
            end
            for (int i = 0; i < 3; i++) sum = sum + (offs[i] >> sh) * (offs[i] >> sh);
            span = floor_root(sum) << sh;
            if (span != 0) g = (64'(k_spring) * 64'(k_rest)) / span;
            for (int i = 0; i < 6; i++) begin
                v = longint'($signed(cur_vel[i]))
                    + spring_pull(raw_s[i] - longint'($signed(cur_pos[i])), g);
                v = clamp32(v);
                prod = v * longint'({48'd0, k_damp});
                dm = abs64(prod) >> 16;
                v = prod < 0 ? v + longint'(dm) : v - longint'(dm);
                cur_vel[i] = v[31:0];
                v = clamp32(longint'($signed(cur_pos[i])) + v);
                cur_pos[i] = v[31:0];
            end
        end
        for (int i = 0; i < 6; i++) exp_pose[i] = cur_pos[i];
        pose_q.push_back(exp_pose);
    endtask

    always @(posedge aclk) begin
        logic [31:0] raw_pt[6];
        pose_t       got;
        pose_t       exp_pose;
        if (!aresetn) begin
            k_spring  = SPRING_GAIN_RST;
            k_damp    = DAMPING_RST;
            k_rest    = REST_DISTANCE_RST;
            want_snap = 1'b1;
            for (int i = 0; i < 6; i++) begin
                cur_pos[i] = 0;
                cur_vel[i] = 0;
            end
            pose_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SPRING_GAIN:   k_spring = cfg_wr_data[15:0];
                    CFG_DAMPING:       k_damp   = cfg_wr_data[15:0];
                    CFG_REST_DISTANCE: k_rest   = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_smooth_aim_z, m_smooth_aim_y, m_smooth_aim_x,
                       m_smooth_eye_z, m_smooth_eye_y, m_smooth_eye_x};
                if (pose_q.size() == 0) begin
                    $display("%0t: result with no request outstanding: %h", $time, got);
                    n_errors++;
                end else begin
                    exp_pose = pose_q.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (got[i] !== exp_pose[i]) begin
                            $display("%0t: axis %0d expected %h actual %h",
                                     $time, i, exp_pose[i], got[i]);
                            n_errors++;
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                raw_pt = '{s_eye_x, s_eye_y, s_eye_z, s_aim_x, s_aim_y, s_aim_z};
                follow_step(raw_pt, s_snap);
            end
        end
        n_pending = pose_q.size();
    end

    final begin
        if (pose_q.size() != 0) $display("%0t: %0d results never arrived", $time, pose_q.size());
    end

endmodule

@@ test/tb_spring_damper_follow_3d.sv @@
// Testbench top for the spring damper follower: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_spring_damper_follow_3d;
    import sdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 140;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_eye_x = '0, s_eye_y = '0, s_eye_z = '0;
    logic signed [31:0] s_aim_x = '0, s_aim_y = '0, s_aim_z = '0;
    logic               s_snap = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_smooth_eye_x, m_smooth_eye_y, m_smooth_eye_z;
    logic signed [31:0] m_smooth_aim_x, m_smooth_aim_y, m_smooth_aim_z;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_wr_data = '0;
    int                 n_pending;
    int                 n_errors;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;
    logic signed [31:0] track[6];

    always #5 aclk = ~aclk;

    spring_damper_follow_3d u_dut (.*);
    sdf_follow_checker u_chk (.*);

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_spring_damper_follow_3d NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic signed [31:0] p[6], input logic snap);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_eye_x, s_eye_y, s_eye_z} <= {p[0], p[1], p[2]};
        {s_aim_x, s_aim_y, s_aim_z} <= {p[3], p[4], p[5]};
        s_snap  <= snap;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Let every outstanding request finish before touching registers.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_same(input logic signed [31:0] e, input logic signed [31:0] a,
                             input logic snap);
        logic signed [31:0] p[6];
        p = '{e, e, e, a, a, a};
        send_request(p, snap);
    endtask

    // Mostly a camera drifting around a slowly moving track, sometimes wild values.
    task automatic send_random();
        logic signed [31:0] p[6];
        int                 r;
        r = $urandom_range(99);
        for (int i = 0; i < 6; i++) begin
            if ($urandom_range(99) < 10) track[i] = track[i] + $signed($urandom_range(65535) << 8)
                                                    - 32'sd8388608;
            if (r < 75) p[i] = track[i] + $signed($urandom_range(2097151)) - 32'sd1048576;
            else p[i] = $urandom;
        end
        send_request(p, $urandom_range(99) < 4);
    endtask

    initial begin
        logic [31:0] cfg_set[7][3];
        cfg_set = '{'{32'd1638, 32'd32768, 32'd655360},
                    '{32'd0, 32'd0, 32'd0},
                    '{32'd65535, 32'd65535, 32'hFFFF_FFFF},
                    '{32'd65535, 32'd0, 32'd655360},
                    '{32'd6553, 32'd16384, 32'd131072},
                    '{32'hFFFF_0800, 32'hABCD_4000, 32'd6553600},
                    '{32'd1638, 32'd65535, 32'd0}};
        for (int i = 0; i < 6; i++) track[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first request snaps, then extremes, coincident points, far points.
        send_same(32'sd65536, -32'sd65536, 1'b0);
        send_same(32'sd131072, 32'sd0, 1'b0);
        send_same(32'sd100, 32'sd100, 1'b0);
        send_same(32'sh7fffffff, 32'sh80000000, 1'b0);
        send_same(32'sh80000000, 32'sh7fffffff, 1'b0);
        send_same(32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_same(32'sh80000000, 32'sh80000000, 1'b1);
        send_same(32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_same(-32'sd1, 32'sd0, 1'b0);
        send_same(32'sd0, 32'sd0, 1'b1);
        send_same(32'sd655360, 32'sd0, 1'b0);
        send_same(32'sd655360, 32'sd0, 1'b0);
        send_same(32'shFFFFFFFF, 32'sh55555555, 1'b0);
        send_same(32'shAAAAAAAA, 32'sh00000000, 1'b0);
        drain();
        write_reg(2'd3, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 7; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            write_reg(CFG_SPRING_GAIN, cfg_set[ph][0]);
            write_reg(CFG_DAMPING, cfg_set[ph][1]);
            write_reg(CFG_REST_DISTANCE, cfg_set[ph][2]);
            for (int n = 0; n < 276; n++) send_random();
            drain();
        end

        if (n_errors == 0) begin
            $display("tb_spring_damper_follow_3d OK");
        end else begin
            $display("tb_spring_damper_follow_3d NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/sdf_pkg.sv
design/sdf_isqrt.sv
design/sdf_div.sv
design/spring_damper_follow_3d.sv
design/sdf_checker.sv
test/sdf_follow_checker.sv
test/tb_spring_damper_follow_3d.sv
